FILE: rtl/rpot_pkg.sv
// ----------------------------------------------------------------------------
// rpot_pkg
// Shared constants and types for the rectangle pair overlap test.
// ----------------------------------------------------------------------------
package rpot_pkg;

   // corners per rectangle and coordinates per rectangle (x,y pairs)
   localparam int CORNERS = 4;
   localparam int COORDS  = 8;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // item action codes
   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_TEST = 1'b1
   } action_type;

endpackage

FILE: rtl/rect_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// rect_pair_overlap_test
// Separating axis overlap test of two oriented rectangles in fixed point.
// ----------------------------------------------------------------------------
// One item per cycle is taken in unless a test waits on a full queue, and
// one result per cycle is given out while rsp_ready holds. A load item
// (action 0) replaces the reference rectangle and returns no result; a
// test item (action 1) returns one collide bit. The front register adds
// the position to the corners, a four-entry queue decouples it from the
// back pipeline (axes, multipliers, dot sums, interval compare), so a held
// result stalls only the back until the queue fills. Tests use the
// reference as it stood when they were accepted. After reset the reference
// is all zero, so tests report no collision until a load arrives.
module rect_pair_overlap_test #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic signed [COORD_WIDTH-1:0] req_ul_x,
   input  logic signed [COORD_WIDTH-1:0] req_ul_y,
   input  logic signed [COORD_WIDTH-1:0] req_ur_x,
   input  logic signed [COORD_WIDTH-1:0] req_ur_y,
   input  logic signed [COORD_WIDTH-1:0] req_lr_x,
   input  logic signed [COORD_WIDTH-1:0] req_lr_y,
   input  logic signed [COORD_WIDTH-1:0] req_ll_x,
   input  logic signed [COORD_WIDTH-1:0] req_ll_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_collide
);

   localparam int QW = 2 * rpot_pkg::COORDS * (COORD_WIDTH + 1);

   logic signed [COORD_WIDTH-1:0] coord [rpot_pkg::COORDS];
   logic                          push_valid, push_ready;
   logic [QW-1:0]                 push_data;
   logic                          pop_valid, pop_ready;
   logic [QW-1:0]                 pop_data;

   // corners as x,y pairs: UL, UR, LR, LL
   assign coord[0] = req_ul_x;
   assign coord[1] = req_ul_y;
   assign coord[2] = req_ur_x;
   assign coord[3] = req_ur_y;
   assign coord[4] = req_lr_x;
   assign coord[5] = req_lr_y;
   assign coord[6] = req_ll_x;
   assign coord[7] = req_ll_y;

   rpot_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_action  (req_action),
      .in_coord   (coord),
      .in_pos_x   (req_pos_x),
      .in_pos_y   (req_pos_y),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rpot_queue #(
      .DATA_WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rpot_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_collide (rsp_collide)
   );

endmodule

FILE: rtl/rpot_front.sv
// ----------------------------------------------------------------------------
// rpot_front
// Accepts items, adds the position to the corners and classifies them.
// Load items update the reference; test items are pushed with a snapshot
// of the reference so later loads cannot disturb them.
// ----------------------------------------------------------------------------
module rpot_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic                                    in_action,
   input  logic signed [COORD_WIDTH-1:0]           in_coord [rpot_pkg::COORDS],
   input  logic signed [COORD_WIDTH-1:0]           in_pos_x,
   input  logic signed [COORD_WIDTH-1:0]           in_pos_y,
   output logic                                    push_valid,
   input  logic                                    push_ready,
   output logic [2*rpot_pkg::COORDS*(COORD_WIDTH+1)-1:0] push_data
);

   localparam int CW = COORD_WIDTH + 1;

   logic                  f_valid_ff, f_valid_in;
   rpot_pkg::action_type  f_action_ff;
   logic signed [CW-1:0]  f_corner_ff [rpot_pkg::COORDS];
   logic signed [CW-1:0]  f_corner_in [rpot_pkg::COORDS];
   logic signed [CW-1:0]  ref_ff      [rpot_pkg::COORDS];
   logic                  f_advance;
   logic                  is_test;

   // world corners: even slots are x, odd slots are y
   always_comb begin
      for (int k = 0; k < rpot_pkg::COORDS; k++) begin
         if (k % 2 == 0) begin
            f_corner_in[k] = CW'(in_coord[k]) + CW'(in_pos_x);
         end else begin
            f_corner_in[k] = CW'(in_coord[k]) + CW'(in_pos_y);
         end
      end
   end

   // handshake: loads always retire, tests wait for queue space
   assign is_test    = (f_action_ff == rpot_pkg::ACTION_TEST);
   assign f_advance  = f_valid_ff && (!is_test || push_ready);
   assign in_ready   = !f_valid_ff || f_advance;
   assign push_valid = f_valid_ff && is_test;
   assign f_valid_in = in_ready ? in_valid : f_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         f_action_ff <= rpot_pkg::action_type'(in_action);
         f_corner_ff <= f_corner_in;
      end
   end

   // reference rectangle, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rpot_pkg::COORDS; k++) begin
            ref_ff[k] <= '0;
         end
      end else if (f_valid_ff && !is_test) begin
         ref_ff <= f_corner_ff;
      end
   end

   // pack test corners low, reference corners high
   always_comb begin
      for (int k = 0; k < rpot_pkg::COORDS; k++) begin
         push_data[k*CW +: CW]                     = f_corner_ff[k];
         push_data[(k+rpot_pkg::COORDS)*CW +: CW]  = ref_ff[k];
      end
   end

endmodule

FILE: rtl/rpot_queue.sv
// ----------------------------------------------------------------------------
// rpot_queue
// Small FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module rpot_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int DEPTH = rpot_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/rpot_back.sv
// ----------------------------------------------------------------------------
// rpot_back
// Separating axis evaluation: axes, products, dot sums, then interval
// compare. Four register stages that advance together unless the result
// register is held.
// ----------------------------------------------------------------------------
module rpot_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          pop_valid,
   output logic                                          pop_ready,
   input  logic [2*rpot_pkg::COORDS*(COORD_WIDTH+1)-1:0] pop_data,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic                                          rsp_collide
);

   localparam int CW = COORD_WIDTH + 1;       // world corner
   localparam int AW = COORD_WIDTH + 2;       // axis component
   localparam int PW = 2 * COORD_WIDTH + 3;   // one product
   localparam int SW = 2 * COORD_WIDTH + 4;   // dot product
   localparam int NC = rpot_pkg::CORNERS;
   localparam int NA = 4;                     // axes

   logic                 enable;
   logic signed [CW-1:0] t_c [rpot_pkg::COORDS];
   logic signed [CW-1:0] r_c [rpot_pkg::COORDS];

   // stage 1: corners and axes
   logic                 b1_valid_ff;
   logic signed [CW-1:0] b1_c_ff  [2][rpot_pkg::COORDS];
   logic signed [AW-1:0] b1_ax_ff [NA];
   logic signed [AW-1:0] b1_ay_ff [NA];
   logic signed [AW-1:0] b1_ax_in [NA];
   logic signed [AW-1:0] b1_ay_in [NA];
   logic [NA-1:0]        b1_nz_ff, b1_nz_in;

   // stage 2: products, [axis][0=ref,1=test][corner]
   logic                 b2_valid_ff;
   logic signed [PW-1:0] b2_px_ff [NA][2][NC];
   logic signed [PW-1:0] b2_py_ff [NA][2][NC];
   logic [NA-1:0]        b2_nz_ff;

   // stage 3: dot products
   logic                 b3_valid_ff;
   logic signed [SW-1:0] b3_dot_ff [NA][2][NC];
   logic [NA-1:0]        b3_nz_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_collide_ff, rsp_collide_in;

   assign enable      = !rsp_valid_ff || rsp_ready;
   assign pop_ready   = enable;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_collide = rsp_collide_ff;

   // unpack queue entry
   always_comb begin
      for (int k = 0; k < rpot_pkg::COORDS; k++) begin
         t_c[k] = $signed(pop_data[k*CW +: CW]);
         r_c[k] = $signed(pop_data[(k+rpot_pkg::COORDS)*CW +: CW]);
      end
   end

   // axes: R.UR-R.UL, R.UR-R.LR, T.UL-T.LL, T.UL-T.UR
   always_comb begin
      b1_ax_in[0] = AW'(r_c[2]) - AW'(r_c[0]);
      b1_ay_in[0] = AW'(r_c[3]) - AW'(r_c[1]);
      b1_ax_in[1] = AW'(r_c[2]) - AW'(r_c[4]);
      b1_ay_in[1] = AW'(r_c[3]) - AW'(r_c[5]);
      b1_ax_in[2] = AW'(t_c[0]) - AW'(t_c[6]);
      b1_ay_in[2] = AW'(t_c[1]) - AW'(t_c[7]);
      b1_ax_in[3] = AW'(t_c[0]) - AW'(t_c[2]);
      b1_ay_in[3] = AW'(t_c[1]) - AW'(t_c[3]);
      for (int a = 0; a < NA; a++) begin
         b1_nz_in[a] = (b1_ax_in[a] != '0) || (b1_ay_in[a] != '0);
      end
   end

   // interval overlap on every axis, inclusive
   always_comb begin
      logic lo_ok, hi_ok;
      rsp_collide_in = 1'b1;
      for (int a = 0; a < NA; a++) begin
         lo_ok = 1'b0;
         hi_ok = 1'b0;
         for (int i = 0; i < NC; i++) begin
            for (int j = 0; j < NC; j++) begin
               lo_ok = lo_ok | (b3_dot_ff[a][1][i] <= b3_dot_ff[a][0][j]);
               hi_ok = hi_ok | (b3_dot_ff[a][0][j] <= b3_dot_ff[a][1][i]);
            end
         end
         rsp_collide_in = rsp_collide_in & b3_nz_ff[a] & lo_ok & hi_ok;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         b1_valid_ff  <= pop_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         rsp_valid_ff <= b3_valid_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         b1_c_ff[0] <= r_c;
         b1_c_ff[1] <= t_c;
         b1_ax_ff   <= b1_ax_in;
         b1_ay_ff   <= b1_ay_in;
         b1_nz_ff   <= b1_nz_in;
         for (int a = 0; a < NA; a++) begin
            for (int s = 0; s < 2; s++) begin
               for (int k = 0; k < NC; k++) begin
                  b2_px_ff[a][s][k] <= PW'(b1_c_ff[s][2*k]) * PW'(b1_ax_ff[a]);
                  b2_py_ff[a][s][k] <= PW'(b1_c_ff[s][2*k+1]) * PW'(b1_ay_ff[a]);
                  b3_dot_ff[a][s][k] <= SW'(b2_px_ff[a][s][k]) + SW'(b2_py_ff[a][s][k]);
               end
            end
         end
         b2_nz_ff       <= b1_nz_ff;
         b3_nz_ff       <= b2_nz_ff;
         rsp_collide_ff <= rsp_collide_in;
      end
   end

endmodule
